>>> src/slpg_pkg.sv
// ----------------------------------------------------------------------------
// Status LED pattern generator: shared package
// Beat types, mode and kind codes, reciprocal constants and the SOS table.
// ----------------------------------------------------------------------------
package slpg_pkg;

   // time stamp width
   localparam int TIME_W = 32;

   // item kinds
   localparam logic [1:0] KIND_UPDATE    = 2'd0;
   localparam logic [1:0] KIND_SET_MODE  = 2'd1;
   localparam logic [1:0] KIND_FORCE_OFF = 2'd2;

   // display modes; code seven has no meaning and is never stored
   typedef enum logic [2:0] {
      MODE_OFF        = 3'd0,
      MODE_ARMED      = 3'd1,
      MODE_GPS        = 3'd2,
      MODE_ALERT      = 3'd3,
      MODE_SETUP      = 3'd4,
      MODE_CONNECTING = 3'd5,
      MODE_ERROR      = 3'd6
   } mode_type;

   localparam logic [2:0] MODE_CODE_NONE = 3'd7;

   // reciprocals for exact division by constants
   // t / 10        = (t * RECIP_10)  >> 35, exact for 32-bit t
   // (t>>4) / 125  = (x * RECIP_125) >> 35, exact for 28-bit x
   // (t>>6) / 25   = (z * RECIP_25)  >> 32, exact for 26-bit z
   localparam logic [63:0] RECIP_10  = 64'd3435973837;
   localparam logic [63:0] RECIP_125 = 64'd274877907;
   localparam logic [63:0] RECIP_25  = 64'd171798692;

   // SOS blink: last step index
   localparam logic [4:0] SOS_LAST = 5'd17;

   // input beat
   typedef struct packed {
      logic [1:0]        kind;
      logic [2:0]        new_mode;
      logic [TIME_W-1:0] now_ms;
   } req_type;

   // result beat
   typedef struct packed {
      logic [7:0] red;
      logic [7:0] green;
      logic [7:0] blue;
   } rsp_type;

   // registered beat with low bytes of the precomputed quotients
   typedef struct packed {
      logic [1:0]        kind;
      logic [2:0]        new_mode;
      logic [TIME_W-1:0] now_ms;
      logic [7:0]        div10;     // t / 10, low byte
      logic [7:0]        div2000;   // t / 2000, low byte
      logic [7:0]        div1600;   // t / 1600, low byte
   } stage_type;

   // core handshake towards the result register
   typedef struct packed {
      logic    has_rsp;
      rsp_type colour;
   } core_out_type;

   // SOS step durations in ms
   function automatic logic [9:0] sos_duration(input logic [4:0] step);
      logic [9:0] dur;
      case (step)
         5'd5, 5'd11: dur = 10'd300;
         5'd6, 5'd8, 5'd10: dur = 10'd450;
         5'd17: dur = 10'd600;
         default: dur = 10'd150;
      endcase
      return dur;
   endfunction

   // triangle wave: p in 0..199 gives 2p rising, then 2(200-p) falling
   function automatic logic [7:0] tri_level(input logic [7:0] p);
      logic [7:0] fall;
      fall = 8'd200 - p;
      return (p < 8'd100) ? {p[6:0], 1'b0} : {fall[6:0], 1'b0};
   endfunction

   // p mod 200 from low bytes: q - 200*b, exact because the result is below 256
   function automatic logic [7:0] phase200(input logic [7:0] q, input logic [7:0] b);
      logic [7:0] m;
      m = {b[0], 7'd0} + {b[1:0], 6'd0} + {b[4:0], 3'd0};
      return q - m;
   endfunction

endpackage

>>> src/slpg_front.sv
// ----------------------------------------------------------------------------
// Status LED pattern generator: input stage
// Registers the accepted beat with the time quotients for the breathing modes.
// ----------------------------------------------------------------------------
module slpg_front (
   input  logic                clock,
   input  logic                reset,
   input  logic                load,
   input  logic                drain,
   input  slpg_pkg::req_type   req,
   output logic                valid,
   output slpg_pkg::stage_type stage
);
   import slpg_pkg::*;

   logic        valid_ff, valid_in;
   stage_type   stage_ff, stage_in;
   logic [63:0] prod10, prod125, prod25;

   // reciprocal multiplies, one level each, straight into the register
   always_comb begin
      prod10  = {32'd0, req.now_ms} * RECIP_10;
      prod125 = {36'd0, req.now_ms[TIME_W-1:4]} * RECIP_125;
      prod25  = {38'd0, req.now_ms[TIME_W-1:6]} * RECIP_25;
   end

   // next beat
   always_comb begin
      stage_in = stage_ff;
      if (load) begin
         stage_in.kind     = req.kind;
         stage_in.new_mode = req.new_mode;
         stage_in.now_ms   = req.now_ms;
         stage_in.div10    = prod10[42:35];
         stage_in.div2000  = prod125[42:35];
         stage_in.div1600  = prod25[39:32];
      end
   end

   // occupancy
   always_comb begin
      if (load) begin
         valid_in = 1'b1;
      end else if (drain) begin
         valid_in = 1'b0;
      end else begin
         valid_in = valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      stage_ff <= stage_in;
   end

   assign valid = valid_ff;
   assign stage = stage_ff;

endmodule

>>> src/slpg_core.sv
// ----------------------------------------------------------------------------
// Status LED pattern generator: mode state and colour logic
// Holds mode, SOS step and step start; works out the colour of each beat.
// ----------------------------------------------------------------------------
module slpg_core (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   fire,
   input  slpg_pkg::stage_type    stage,
   output slpg_pkg::core_out_type result
);
   import slpg_pkg::*;

   mode_type          mode_ff, mode_in;
   logic [4:0]        step_ff, step_in;
   logic [TIME_W-1:0] start_ff, start_in;

   logic [4:0]        step_cur;
   logic [4:0]        step_adv;
   logic [TIME_W-1:0] elapsed;
   logic              step_due;
   logic [7:0]        p_gps, p_conn, v_gps, v_conn;

   // SOS step timing, wrapping time difference
   always_comb begin
      step_cur = (step_ff > SOS_LAST) ? 5'd0 : step_ff;
      elapsed  = stage.now_ms - start_ff;
      step_due = elapsed >= {{(TIME_W-10){1'b0}}, sos_duration(step_cur)};
      if (!step_due) begin
         step_adv = step_cur;
      end else if (step_cur == SOS_LAST) begin
         step_adv = 5'd0;
      end else begin
         step_adv = step_cur + 5'd1;
      end
   end

   // breathing phases: (t/10) mod 200 and (t/8) mod 200
   always_comb begin
      p_gps  = phase200(stage.div10, stage.div2000);
      p_conn = phase200(stage.now_ms[10:3], stage.div1600);
      v_gps  = tri_level(p_gps);
      v_conn = tri_level(p_conn);
   end

   // next state
   always_comb begin
      mode_in  = mode_ff;
      step_in  = step_ff;
      start_in = start_ff;
      if (fire) begin
         case (stage.kind)
            KIND_SET_MODE: begin
               if (stage.new_mode != MODE_CODE_NONE && stage.new_mode != mode_ff) begin
                  mode_in  = mode_type'(stage.new_mode);
                  step_in  = 5'd0;
                  start_in = stage.now_ms;
               end
            end
            KIND_FORCE_OFF: begin
               mode_in = MODE_OFF;
            end
            KIND_UPDATE: begin
               if (mode_ff == MODE_ALERT) begin
                  step_in = step_adv;
                  if (step_due) begin
                     start_in = stage.now_ms;
                  end
               end
            end
            default: begin
            end
         endcase
      end
   end

   // colour output
   always_comb begin
      result.has_rsp = (stage.kind == KIND_UPDATE) || (stage.kind == KIND_FORCE_OFF);
      result.colour  = '0;
      if (stage.kind == KIND_UPDATE) begin
         case (mode_ff)
            MODE_ARMED: result.colour = '{red: 8'd0, green: 8'd180, blue: 8'd0};
            MODE_GPS: result.colour = '{red: v_gps, green: {1'b0, v_gps[7:1]}, blue: 8'd0};
            MODE_ALERT: begin
               if (!step_adv[0]) begin
                  result.colour = '{red: 8'd255, green: 8'd0, blue: 8'd0};
               end
            end
            MODE_SETUP: result.colour = '{red: 8'd0, green: 8'd60, blue: 8'd255};
            MODE_CONNECTING: result.colour = '{red: 8'd0, green: v_conn, blue: v_conn};
            MODE_ERROR: result.colour = '{red: 8'd255, green: 8'd0, blue: 8'd0};
            default: result.colour = '0;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff  <= MODE_OFF;
         step_ff  <= 5'd0;
         start_ff <= '0;
      end else begin
         mode_ff  <= mode_in;
         step_ff  <= step_in;
         start_ff <= start_in;
      end
   end

   // step index never leaves the table
   a_step_range: assert property (@(posedge clock) disable iff (reset)
      step_ff <= SOS_LAST)
      else $error("SOS step out of table");

endmodule

>>> src/status_led_pattern_generator_top.sv
// ----------------------------------------------------------------------------
// Status LED pattern generator: top level
// Two-stage pipeline from millisecond time stamps to RGB status colours.
// ----------------------------------------------------------------------------
// Usage:
//   req_ channel: one beat per command (update, set mode, force off) with the
//   current millisecond time stamp. rsp_ channel: one RGB beat for every
//   update and force-off beat, none for set mode or the unused kind code.
//   A beat accepted into the input register reaches the result register, and
//   so rsp_data, when the stage fires. Throughput is one beat per cycle while
//   no held result stalls; the reciprocal multipliers before the input register
//   and the mode/colour logic after it are each one register stage deep.
//   Reset (synchronous) empties both stages and puts the block in mode off,
//   SOS step 0, step start 0.
//   A stalled result holds rsp_data; one further beat is taken into the
//   input stage, then req_stall rises until the result is taken.
// ----------------------------------------------------------------------------
module status_led_pattern_generator_top (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  slpg_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output slpg_pkg::rsp_type rsp_data
);
   import slpg_pkg::*;

   logic         stage_valid;
   stage_type    stage;
   core_out_type core_out;
   logic         advance, fire, load;
   logic         rsp_valid_ff, rsp_valid_in;
   rsp_type      rsp_ff, rsp_in;

   // pipeline control
   always_comb begin
      advance   = !rsp_valid_ff || !rsp_stall;
      fire      = stage_valid && advance;
      req_stall = stage_valid && !advance;
      load      = req_valid && !req_stall;
   end

   slpg_front u_front (
      .clock (clock),
      .reset (reset),
      .load  (load),
      .drain (fire),
      .req   (req_data),
      .valid (stage_valid),
      .stage (stage)
   );

   slpg_core u_core (
      .clock  (clock),
      .reset  (reset),
      .fire   (fire),
      .stage  (stage),
      .result (core_out)
   );

   // result register
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_in       = rsp_ff;
      if (fire) begin
         rsp_valid_in = core_out.has_rsp;
         if (core_out.has_rsp) begin
            rsp_in = core_out.colour;
         end
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_ff <= rsp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   // input back-pressure only while the stage holds a beat
   a_stall_needs_beat: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> stage_valid)
      else $error("input stalled with empty stage");

   // a held result blocks the stage
   a_no_fire_on_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_stall) |-> !fire)
      else $error("stage drained over a held result");

   // a new result only comes from a drained beat
   a_rsp_from_fire: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(fire))
      else $error("result appeared without a beat");

endmodule
